// File: rtl/stack_bytecode_evaluator_macros.svh
`ifndef STACK_BYTECODE_EVALUATOR_MACROS_SVH
`define STACK_BYTECODE_EVALUATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define SBE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbe_pkg;

  localparam int STACK_SIZE_DEF = 256;

  localparam logic [7:0] OPC_PUSH = 8'd0;
  localparam logic [7:0] OPC_ADD  = 8'd1;
  localparam logic [7:0] OPC_SUB  = 8'd2;
  localparam logic [7:0] OPC_MUL  = 8'd3;
  localparam logic [7:0] OPC_DIV  = 8'd4;
  localparam logic [7:0] OPC_NEG  = 8'd5;
  localparam logic [7:0] OPC_RET  = 8'd6;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_RETURNED      = 3'd1;
  localparam logic [2:0] ST_COMPILE_ERROR = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW     = 3'd3;
  localparam logic [2:0] ST_OVERFLOW      = 3'd4;

  localparam logic [1:0] FOP_ADD = 2'd0;
  localparam logic [1:0] FOP_SUB = 2'd1;
  localparam logic [1:0] FOP_MUL = 2'd2;
  localparam logic [1:0] FOP_DIV = 2'd3;

  localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
  localparam logic [63:0] DEF_NAN   = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] DIV0_NAN  = 64'h7FF8_0000_0000_0000;
  localparam logic [10:0] EXP_MAX   = 11'h7FF;

  typedef struct packed {
    logic       ld_in;
    logic       rd_second;
    logic       ld_b;
    logic       fpu_start;
    logic       wr_push;
    logic       wr_neg;
    logic       wr_fpu;
    logic       ret_ld;
    logic       depth_inc;
    logic       depth_dec;
    logic       ld_out;
    logic [2:0] status;
  } ctl_cmd_t;

  typedef struct packed {
    logic [7:0] opcode;
    logic       empty;
    logic       lt2;
    logic       full;
    logic       fpu_done;
  } ctl_stat_t;

endpackage

`default_nettype wire

// File: rtl/sbe_fpu.sv
`timescale 1ns / 1ps
`default_nettype none

module sbe_fpu (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [1:0]  op,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      result
);
  import sbe_pkg::*;

  localparam logic [2:0] F_IDLE   = 3'd0;
  localparam logic [2:0] F_PRE    = 3'd1;
  localparam logic [2:0] F_MUL    = 3'd2;
  localparam logic [2:0] F_DIV    = 3'd3;
  localparam logic [2:0] F_NORM   = 3'd4;
  localparam logic [2:0] F_DENORM = 3'd5;
  localparam logic [2:0] F_ROUND  = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic               done_r;
  logic [63:0]        res_r;
  logic [1:0]         op_r;
  logic               s_r, zs_r;
  logic signed [13:0] e_r, ea_r, eb_r;
  logic [56:0]        m_r;
  logic [52:0]        ma_r, mb_r;
  logic [55:0]        mbs_r;
  logic [108:0]       prod_r;
  logic [53:0]        rem_r;
  logic [56:0]        q_r;
  logic [5:0]         cnt_r;

  logic        sa, sbe, sx;
  logic [10:0] xa, xb;
  logic [51:0] fa, fb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic        spec;
  logic [63:0] spec_val;

  logic        a_big, eff_sub, lost;
  logic [10:0] big_x, sm_x, ebig, esm, dsh;
  logic [51:0] big_f, sm_f;
  logic [55:0] sm_m, al_sh, al;
  logic [56:0] big_m, sum;

  logic [60:0]  pp;
  logic [108:0] prod_nxt;
  logic [54:0]  diff;
  logic         ge;

  logic               up, normal;
  logic [53:0]        rnd;
  logic signed [13:0] e_fin;
  logic [63:0]        packed_val;

  always_comb begin
    sa = a[63];
    sbe = b[63] ^ (op == FOP_SUB);
    sx = a[63] ^ b[63];
    xa = a[62:52];
    xb = b[62:52];
    fa = a[51:0];
    fb = b[51:0];
    nan_a = (xa == EXP_MAX) && (fa != 52'd0);
    nan_b = (xb == EXP_MAX) && (fb != 52'd0);
    inf_a = (xa == EXP_MAX) && (fa == 52'd0);
    inf_b = (xb == EXP_MAX) && (fb == 52'd0);
    zero_a = (a[62:0] == 63'd0);
    zero_b = (b[62:0] == 63'd0);
    spec = 1'b1;
    spec_val = 64'd0;
    case (op)
      FOP_ADD, FOP_SUB: begin
        if (nan_a) spec_val = a | QUIET_BIT;
        else if (nan_b) spec_val = b | QUIET_BIT;
        else if (inf_a && inf_b) spec_val = (sa == sbe) ? a : DEF_NAN;
        else if (inf_a) spec_val = a;
        else if (inf_b) spec_val = {sbe, EXP_MAX, 52'd0};
        else spec = 1'b0;
      end
      FOP_MUL: begin
        if (nan_a) spec_val = a | QUIET_BIT;
        else if (nan_b) spec_val = b | QUIET_BIT;
        else if ((inf_a && zero_b) || (zero_a && inf_b)) spec_val = DEF_NAN;
        else if (inf_a || inf_b) spec_val = {sx, EXP_MAX, 52'd0};
        else if (zero_a || zero_b) spec_val = {sx, 63'd0};
        else spec = 1'b0;
      end
      default: begin
        if (zero_b) begin
          if (nan_a) spec_val = a | QUIET_BIT;
          else if (zero_a) spec_val = DIV0_NAN;
          else spec_val = {sx, EXP_MAX, 52'd0};
        end else if (nan_a) spec_val = a | QUIET_BIT;
        else if (nan_b) spec_val = b | QUIET_BIT;
        else if (inf_a && inf_b) spec_val = DEF_NAN;
        else if (inf_a) spec_val = {sx, EXP_MAX, 52'd0};
        else if (inf_b || zero_a) spec_val = {sx, 63'd0};
        else spec = 1'b0;
      end
    endcase
  end

  always_comb begin
    a_big = (a[62:0] >= b[62:0]);
    eff_sub = sa ^ sbe;
    big_x = a_big ? xa : xb;
    sm_x = a_big ? xb : xa;
    big_f = a_big ? fa : fb;
    sm_f = a_big ? fb : fa;
    ebig = (big_x == 11'd0) ? 11'd1 : big_x;
    esm = (sm_x == 11'd0) ? 11'd1 : sm_x;
    dsh = ebig - esm;
    sm_m = {(sm_x != 11'd0), sm_f, 3'b000};
    al_sh = sm_m >> dsh[5:0];
    lost = |(sm_m & ~({56{1'b1}} << dsh[5:0]));
    if (dsh >= 11'd56) al = {55'd0, |sm_m};
    else al = {al_sh[55:1], al_sh[0] | lost};
    big_m = {1'b0, (big_x != 11'd0), big_f, 3'b000};
    sum = eff_sub ? (big_m - {1'b0, al}) : (big_m + {1'b0, al});
  end

  always_comb begin
    pp = ma_r * mbs_r[55:48];
    prod_nxt = {prod_r[100:0], 8'd0} + {48'd0, pp};
    diff = {1'b0, rem_r} - {2'b00, mb_r};
    ge = ~diff[54];
  end

  always_comb begin
    up = m_r[2] & (m_r[3] | m_r[1] | m_r[0]);
    rnd = {1'b0, m_r[55:3]} + {53'd0, up};
    e_fin = e_r + {13'd0, rnd[53]};
    normal = rnd[53] | rnd[52];
    if (e_fin >= 14'sd2047) packed_val = {s_r, EXP_MAX, 52'd0};
    else packed_val = {s_r, (normal ? e_fin[10:0] : 11'd0), (rnd[53] ? 52'd0 : rnd[51:0])};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (start && !spec) begin
          state_nxt = (op == FOP_ADD || op == FOP_SUB) ? F_NORM : F_PRE;
        end
      end
      F_PRE: begin
        if (ma_r[52] && mb_r[52]) state_nxt = (op_r == FOP_MUL) ? F_MUL : F_DIV;
      end
      F_MUL: if (cnt_r == 6'd7) state_nxt = F_NORM;
      F_DIV: if (cnt_r == 6'd57) state_nxt = F_NORM;
      F_NORM: begin
        if (m_r == 57'd0) state_nxt = F_IDLE;
        else if (!m_r[56] && (m_r[55] || e_r <= 14'sd1)) state_nxt = F_DENORM;
      end
      F_DENORM: if (e_r >= 14'sd1) state_nxt = F_ROUND;
      F_ROUND: state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r <= 1'b0;
      if (state_r == F_IDLE && start && spec) done_r <= 1'b1;
      if (state_r == F_NORM && m_r == 57'd0) done_r <= 1'b1;
      if (state_r == F_ROUND) done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      F_IDLE: begin
        if (start) begin
          op_r <= op;
          res_r <= spec_val;
          cnt_r <= 6'd0;
          if (op == FOP_ADD || op == FOP_SUB) begin
            s_r <= a_big ? sa : sbe;
            zs_r <= sa & sbe;
            e_r <= signed'({3'd0, ebig});
            m_r <= sum;
          end else begin
            s_r <= sx;
            zs_r <= sx;
            ma_r <= {(xa != 11'd0), fa};
            mb_r <= {(xb != 11'd0), fb};
            ea_r <= signed'({3'd0, ((xa == 11'd0) ? 11'd1 : xa)});
            eb_r <= signed'({3'd0, ((xb == 11'd0) ? 11'd1 : xb)});
          end
        end
      end
      F_PRE: begin
        if (ma_r[52] && mb_r[52]) begin
          prod_r <= 109'd0;
          mbs_r <= {mb_r, 3'b000};
          rem_r <= {1'b0, ma_r};
          q_r <= 57'd0;
        end else begin
          if (!ma_r[52]) begin
            ma_r <= {ma_r[51:0], 1'b0};
            ea_r <= ea_r - 14'sd1;
          end
          if (!mb_r[52]) begin
            mb_r <= {mb_r[51:0], 1'b0};
            eb_r <= eb_r - 14'sd1;
          end
        end
      end
      F_MUL: begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd7) begin
          m_r <= {1'b0, prod_r[108:54], prod_r[53] | (|prod_r[52:0])};
          e_r <= ea_r + eb_r - 14'sd1022;
        end else begin
          prod_r <= prod_nxt;
          mbs_r <= {mbs_r[47:0], 8'd0};
        end
      end
      F_DIV: begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd57) begin
          m_r <= {q_r[56:1], q_r[0] | (rem_r != 54'd0)};
          e_r <= ea_r - eb_r + 14'sd1022;
        end else begin
          q_r <= {q_r[55:0], ge};
          rem_r <= ge ? {diff[52:0], 1'b0} : {rem_r[52:0], 1'b0};
        end
      end
      F_NORM: begin
        if (m_r == 57'd0) begin
          res_r <= {zs_r, 63'd0};
        end else if (m_r[56]) begin
          m_r <= {1'b0, m_r[56:2], m_r[1] | m_r[0]};
          e_r <= e_r + 14'sd1;
        end else if (!m_r[55] && e_r > 14'sd1) begin
          m_r <= {m_r[55:0], 1'b0};
          e_r <= e_r - 14'sd1;
        end
      end
      F_DENORM: begin
        if (e_r < -14'sd57) begin
          m_r <= {56'd0, |m_r};
          e_r <= 14'sd1;
        end else if (e_r < 14'sd1) begin
          m_r <= {1'b0, m_r[56:2], m_r[1] | m_r[0]};
          e_r <= e_r + 14'sd1;
        end
      end
      F_ROUND: res_r <= packed_val;
      default: ;
    endcase
  end

  assign done = done_r;
  assign result = res_r;

endmodule

`default_nettype wire

// File: rtl/sbe_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sbe_dp #(
  parameter int STACK_SIZE = sbe_pkg::STACK_SIZE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        in_cmd,
  input  wire logic [63:0]       in_constant_value,
  input  wire sbe_pkg::ctl_cmd_t cmd,
  output sbe_pkg::ctl_stat_t     stat,
  output logic [63:0]            out_result_value,
  output logic [2:0]             out_status
);
  import sbe_pkg::*;

  localparam int AW = $clog2(STACK_SIZE);
  localparam int DW = $clog2(STACK_SIZE + 1);

  logic [63:0]   stack_r [STACK_SIZE];
  logic [63:0]   rd_data_r;
  logic [DW-1:0] depth_r;
  logic [7:0]    cmd_r;
  logic [63:0]   const_r, b_r, res_r, out_res_r;
  logic [2:0]    out_st_r;

  logic [DW-1:0] depth_m1, depth_m2;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [63:0]   wr_data;
  logic          wr_en, fpu_done;
  logic [63:0]   fpu_res;
  logic [7:0]    fop_full;

  always_comb begin
    depth_m1 = depth_r - DW'(1);
    depth_m2 = depth_r - DW'(2);
    rd_addr = cmd.rd_second ? depth_m2[AW-1:0] : depth_m1[AW-1:0];
    wr_en = cmd.wr_push | cmd.wr_neg | cmd.wr_fpu;
    if (cmd.wr_push) begin
      wr_addr = depth_r[AW-1:0];
      wr_data = const_r;
    end else if (cmd.wr_neg) begin
      wr_addr = depth_m1[AW-1:0];
      wr_data = rd_data_r ^ SIGN_BIT;
    end else begin
      wr_addr = depth_m2[AW-1:0];
      wr_data = fpu_res;
    end
    fop_full = cmd_r - OPC_ADD;
  end

  always_ff @(posedge clk) begin
    if (wr_en) stack_r[wr_addr] <= wr_data;
    rd_data_r <= stack_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (cmd.depth_inc) begin
      depth_r <= depth_r + DW'(1);
    end else if (cmd.depth_dec) begin
      depth_r <= depth_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      cmd_r <= in_cmd;
      const_r <= in_constant_value;
      res_r <= 64'd0;
    end else if (cmd.ret_ld) begin
      res_r <= rd_data_r;
    end
    if (cmd.ld_b) b_r <= rd_data_r;
    if (cmd.ld_out) begin
      out_res_r <= res_r;
      out_st_r <= cmd.status;
    end
  end

  sbe_fpu u_fpu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.fpu_start),
    .op     (fop_full[1:0]),
    .a      (rd_data_r),
    .b      (b_r),
    .done   (fpu_done),
    .result (fpu_res)
  );

  always_comb begin
    stat.opcode = cmd_r;
    stat.empty = (depth_r == '0);
    stat.lt2 = (depth_r < DW'(2));
    stat.full = (depth_r == DW'(STACK_SIZE));
    stat.fpu_done = fpu_done;
  end

  assign out_result_value = out_res_r;
  assign out_status = out_st_r;

endmodule

`default_nettype wire

// File: rtl/sbe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sbe_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  input  wire sbe_pkg::ctl_stat_t stat,
  output sbe_pkg::ctl_cmd_t       cmd
);
  import sbe_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_TOP    = 3'd2;
  localparam logic [2:0] S_SECOND = 3'd3;
  localparam logic [2:0] S_EXEC   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [2:0] st_r, st_nxt;
  logic       out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.status = st_r;
    state_nxt = state_r;
    st_nxt = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.ld_in = 1'b1;
          st_nxt = ST_OK;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        unique case (stat.opcode) inside
          OPC_PUSH: begin
            if (stat.full) begin
              st_nxt = ST_OVERFLOW;
            end else begin
              cmd.wr_push = 1'b1;
              cmd.depth_inc = 1'b1;
            end
          end
          OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV: begin
            if (stat.lt2) st_nxt = ST_UNDERFLOW;
            else state_nxt = S_TOP;
          end
          OPC_NEG, OPC_RET: begin
            if (stat.empty) st_nxt = ST_UNDERFLOW;
            else state_nxt = S_TOP;
          end
          default: st_nxt = ST_COMPILE_ERROR;
        endcase
      end
      S_TOP: begin
        unique case (stat.opcode) inside
          OPC_NEG: begin
            cmd.wr_neg = 1'b1;
            state_nxt = S_FINISH;
          end
          OPC_RET: begin
            cmd.ret_ld = 1'b1;
            cmd.depth_dec = 1'b1;
            st_nxt = ST_RETURNED;
            state_nxt = S_FINISH;
          end
          default: begin
            cmd.ld_b = 1'b1;
            cmd.rd_second = 1'b1;
            state_nxt = S_SECOND;
          end
        endcase
      end
      S_SECOND: begin
        cmd.fpu_start = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.fpu_done) begin
          cmd.wr_fpu = 1'b1;
          cmd.depth_dec = 1'b1;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.ld_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r <= st_nxt;
      if (cmd.ld_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// File: rtl/stack_bytecode_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none
// Stack bytecode evaluator on IEEE double values.
// Input stream: one instruction per transfer; in_tdata carries the opcode and
// the constant that a push stores. Result stream: one transfer per
// instruction; out_tdata carries the returned value (zero unless returned),
// out_tuser the status code.
// One instruction is in flight at a time; in_tready is high only when idle.
// Push, errors and underflow go from decode straight to the output stage;
// negate and return first read the top entry; add, subtract, multiply and
// divide read two entries and then wait for the iterative float unit
// (8-bit multiply step, 1-bit divide step, 1-bit normalize step), which also
// normalizes subnormal operands and denormalizes subnormal results.
// in_tready rises with out_tvalid.
// The result sits in an output register, so a stalled receiver holds only
// the next instruction's final step; the stack is untouched while waiting.
// Reset empties the stack and drops any pending result; entries need no clear.
module stack_bytecode_evaluator #(
  parameter int STACK_SIZE = sbe_pkg::STACK_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // cmd[7:0], constant_value[71:8]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // result_value[63:0]
  output logic [2:0]       out_tuser   // status[2:0]
);
  import sbe_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  sbe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sbe_dp #(
    .STACK_SIZE (STACK_SIZE)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_cmd            (in_tdata[7:0]),
    .in_constant_value (in_tdata[71:8]),
    .cmd               (cmd),
    .stat              (stat),
    .out_result_value  (out_tdata),
    .out_status        (out_tuser)
  );

endmodule

`default_nettype wire

// File: rtl/sbe_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "stack_bytecode_evaluator_macros.svh"

module sbe_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [2:0]  out_tuser
);
  import sbe_pkg::*;

  `SBE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `SBE_ASSERT_NOW(a_status_range, clk, rst_n, out_tvalid, out_tuser <= ST_OVERFLOW, "status code out of range")
  `SBE_ASSERT_NOW(a_value_zero, clk, rst_n, out_tvalid && out_tuser != ST_RETURNED, out_tdata == 64'd0, "nonzero value without return")
  `SBE_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready, "second transfer taken while busy")

endmodule

bind stack_bytecode_evaluator sbe_checker u_sbe_checker (.*);

`default_nettype wire
